// File: rtl/aabbpo_pkg.sv
`timescale 1ns / 1ps

package aabbpo_pkg;

  // coordinate word, signed, 8 fraction bits
  localparam int CW = 24;
  // half extent word, unsigned
  localparam int HW = CW - 1;
  // search step word
  localparam int STEP_W = 16;
  // search rounds before giving up
  localparam int MAX_ROUNDS = 1024;

  // datapath width: exact for own + offset - query, plus sum of half extents
  localparam int AW = (CW + 4 > STEP_W + 2) ? CW + 4 : STEP_W + 2;
  // push-out threshold is at most twice the sum of half extents
  localparam int DW = CW + 1;
  // width for the round limit compare
  localparam int QCW = DW + 17;
  // config data word
  localparam int CFG_W = (CW > STEP_W) ? CW : STEP_W;
  localparam int IDX_W = 3;
  localparam int DCNT_W = $clog2(DW);

  // config register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_HALF_X = 3'd0,
    REG_HALF_Y = 3'd1,
    REG_HALF_Z = 3'd2,
    REG_OFFS_X = 3'd3,
    REG_OFFS_Y = 3'd4,
    REG_OFFS_Z = 3'd5,
    REG_STEP   = 3'd6
  } reg_idx_t;

  // sign-extend a coordinate to datapath width
  function automatic logic signed [AW-1:0] sext_coord(input logic [CW-1:0] v);
    return {{(AW-CW){v[CW-1]}}, v};
  endfunction

  // zero-extend a half extent to datapath width
  function automatic logic signed [AW-1:0] zext_half(input logic [HW-1:0] v);
    return {{(AW-HW){1'b0}}, v};
  endfunction

  // clamp a datapath value to the signed coordinate range
  function automatic logic [CW-1:0] sat_coord(input logic [AW-1:0] v);
    logic [AW-CW:0] top;
    top = v[AW-1:CW-1];
    if (top == {(AW-CW+1){1'b0}} || top == {(AW-CW+1){1'b1}}) begin
      return v[CW-1:0];
    end else if (v[AW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/aabb_overlap_push_out.sv
`timescale 1ns / 1ps

// Box overlap test with push-out search. One word in gives one word out. All
// arithmetic goes through a single add/subtract unit under a small sequencer:
// it builds the six per-direction free thresholds (three axes, five steps
// each), finds the smallest and tests overlap, then runs a restoring divide by
// step_size, forms the push distance, picks the first free direction in search
// order and moves the centre. A word with no overlap skips the divide and the
// search, and one that runs out of rounds skips the search; a result word still
// held by out_stall adds its wait. The input stalls from the accepted word
// until its result enters the output register. The result sits in an output
// register; the next word is taken while it waits.
// Config registers may be written only while the block is idle.
module aabb_overlap_push_out (
  input  logic                                   clk,
  input  logic                                   rst,
  // config write port
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [aabbpo_pkg::IDX_W-1:0]           cfg_index,
  input  logic [aabbpo_pkg::CFG_W-1:0]           cfg_data,
  // input words
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [aabbpo_pkg::CW-1:0]       own_x,
  input  logic signed [aabbpo_pkg::CW-1:0]       own_y,
  input  logic signed [aabbpo_pkg::CW-1:0]       own_z,
  input  logic signed [aabbpo_pkg::CW-1:0]       query_pos_x,
  input  logic signed [aabbpo_pkg::CW-1:0]       query_pos_y,
  input  logic signed [aabbpo_pkg::CW-1:0]       query_pos_z,
  input  logic [aabbpo_pkg::HW-1:0]              query_half_x,
  input  logic [aabbpo_pkg::HW-1:0]              query_half_y,
  input  logic [aabbpo_pkg::HW-1:0]              query_half_z,
  // result words
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [aabbpo_pkg::CW-1:0]       resolved_x,
  output logic signed [aabbpo_pkg::CW-1:0]       resolved_y,
  output logic signed [aabbpo_pkg::CW-1:0]       resolved_z,
  output logic                                   was_overlapping,
  output logic                                   gave_up
);

  import aabbpo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM_A,
    S_DIFF,
    S_SUM_S,
    S_TPOS,
    S_TNEG,
    S_MIN,
    S_DIV,
    S_DST1,
    S_DST2,
    S_SEL,
    S_MOVE,
    S_FIN
  } state_t;

  state_t state;

  // config registers
  logic [HW-1:0]        half_extent_x, half_extent_y, half_extent_z;
  logic [CW-1:0]        offset_x, offset_y, offset_z;
  logic [STEP_W-1:0]    step_size;

  // latched input, lanes in search order: 0 = x, 1 = z, 2 = y
  logic [CW-1:0]        own_r [3];
  logic [CW-1:0]        qpos [3];
  logic [HW-1:0]        qhalf [3];

  // direction slot: lane = k[2:1], k[0] set for the negative move
  logic [2:0]           k;
  logic [1:0]           lane;

  logic signed [AW-1:0] acen;     // collider centre on current lane
  logic signed [AW-1:0] diff;     // query minus collider centre
  logic signed [AW-1:0] hsum;     // sum of half extents
  logic signed [AW-1:0] tval [6]; // move needed beyond this to free the box
  logic signed [AW-1:0] tmin;
  logic signed [AW-1:0] dst;      // push distance, whole rounds of step
  logic [DW-1:0]        dvd;      // dividend in, quotient out
  logic [STEP_W-1:0]    rem;
  logic [DCNT_W-1:0]    dcnt;
  logic [CW-1:0]        mv;
  logic [1:0]           mv_lane;
  logic                 found;
  logic                 ovl;
  logic                 gave;

  // shared add/subtract unit
  logic signed [AW-1:0] alu_a, alu_b, alu_y;
  logic                 alu_sub;
  logic                 alu_neg;

  logic [HW-1:0]        half_sel;
  logic [CW-1:0]        offs_sel;
  logic signed [AW-1:0] tmin_next;
  logic                 sep_any;
  logic [CW-1:0]        res [3];

  assign lane = k[2:1];
  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  // per-lane config select
  always_comb begin
    case (lane)
      2'd0: begin
        half_sel = half_extent_x;
        offs_sel = offset_x;
      end
      2'd1: begin
        half_sel = half_extent_z;
        offs_sel = offset_z;
      end
      default: begin
        half_sel = half_extent_y;
        offs_sel = offset_y;
      end
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_SUM_A: begin
        alu_a = sext_coord(own_r[lane]);
        alu_b = sext_coord(offs_sel);
      end
      S_DIFF: begin
        alu_a   = sext_coord(qpos[lane]);
        alu_b   = acen;
        alu_sub = 1'b1;
      end
      S_SUM_S: begin
        alu_a = zext_half(half_sel);
        alu_b = zext_half(qhalf[lane]);
      end
      S_TPOS: begin
        alu_a   = hsum;
        alu_b   = diff;
        alu_sub = 1'b1;
      end
      S_TNEG: begin
        alu_a = hsum;
        alu_b = diff;
      end
      S_MIN: begin
        alu_a   = tval[k];
        alu_b   = tmin;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = {{(AW-STEP_W-1){1'b0}}, rem, dvd[DW-1]};
        alu_b   = {{(AW-STEP_W){1'b0}}, step_size};
        alu_sub = 1'b1;
      end
      S_DST1: begin
        alu_a   = tmin;
        alu_b   = {{(AW-STEP_W){1'b0}}, rem};
        alu_sub = 1'b1;
      end
      S_DST2: begin
        alu_a = dst;
        alu_b = {{(AW-STEP_W){1'b0}}, step_size};
      end
      S_SEL: begin
        alu_a   = tval[k];
        alu_b   = dst;
        alu_sub = 1'b1;
      end
      S_MOVE: begin
        alu_a   = sext_coord(qpos[lane]);
        alu_b   = dst;
        alu_sub = k[0];
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_y   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_neg = alu_y[AW-1];

  // running minimum and separation check
  assign tmin_next = alu_neg ? tval[k] : tmin;
  assign sep_any = tval[0][AW-1] | tval[1][AW-1] | tval[2][AW-1] |
                   tval[3][AW-1] | tval[4][AW-1] | tval[5][AW-1];

  // result per lane: moved lane or entry position
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = (found && mv_lane == 2'(i)) ? mv : qpos[i];
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      half_extent_x <= HW'(256);
      half_extent_y <= HW'(256);
      half_extent_z <= HW'(256);
      offset_x      <= '0;
      offset_y      <= '0;
      offset_z      <= '0;
      step_size     <= STEP_W'(26);
    end else begin
      // config writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HALF_X: half_extent_x <= cfg_data[HW-1:0];
          REG_HALF_Y: half_extent_y <= cfg_data[HW-1:0];
          REG_HALF_Z: half_extent_z <= cfg_data[HW-1:0];
          REG_OFFS_X: offset_x <= cfg_data[CW-1:0];
          REG_OFFS_Y: offset_y <= cfg_data[CW-1:0];
          REG_OFFS_Z: offset_z <= cfg_data[CW-1:0];
          REG_STEP:   step_size <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end

      // result word taken; in S_FIN the next word replaces it instead
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            own_r[0] <= own_x;
            own_r[1] <= own_z;
            own_r[2] <= own_y;
            qpos[0]  <= query_pos_x;
            qpos[1]  <= query_pos_z;
            qpos[2]  <= query_pos_y;
            qhalf[0] <= query_half_x;
            qhalf[1] <= query_half_z;
            qhalf[2] <= query_half_y;
            k        <= 3'd0;
            found    <= 1'b0;
            state    <= S_SUM_A;
          end
        end
        S_SUM_A: begin
          acen  <= alu_y;
          state <= S_DIFF;
        end
        S_DIFF: begin
          diff  <= alu_y;
          state <= S_SUM_S;
        end
        S_SUM_S: begin
          hsum  <= alu_y;
          state <= S_TPOS;
        end
        S_TPOS: begin
          tval[k] <= alu_y;
          k       <= k + 3'd1;
          state   <= S_TNEG;
        end
        S_TNEG: begin
          tval[k] <= alu_y;
          if (k == 3'd5) begin
            tmin  <= tval[0];
            k     <= 3'd1;
            state <= S_MIN;
          end else begin
            k     <= k + 3'd1;
            state <= S_SUM_A;
          end
        end
        S_MIN: begin
          tmin <= tmin_next;
          if (k == 3'd5) begin
            if (sep_any) begin
              ovl   <= 1'b0;
              gave  <= 1'b0;
              state <= S_FIN;
            end else begin
              ovl   <= 1'b1;
              dvd   <= tmin_next[DW-1:0];
              rem   <= '0;
              dcnt  <= DCNT_W'(DW - 1);
              state <= S_DIV;
            end
          end else begin
            k <= k + 3'd1;
          end
        end
        // restoring divide: one quotient bit per cycle
        S_DIV: begin
          if (!alu_neg) begin
            rem <= alu_y[STEP_W-1:0];
          end else begin
            rem <= {rem[STEP_W-2:0], dvd[DW-1]};
          end
          dvd <= {dvd[DW-2:0], ~alu_neg};
          if (dcnt == '0) begin
            state <= S_DST1;
          end else begin
            dcnt <= dcnt - DCNT_W'(1);
          end
        end
        // quotient is the last round that does not free the box
        S_DST1: begin
          if ({17'b0, dvd} >= QCW'(MAX_ROUNDS)) begin
            gave  <= 1'b1;
            state <= S_FIN;
          end else begin
            gave  <= 1'b0;
            dst   <= alu_y;
            state <= S_DST2;
          end
        end
        S_DST2: begin
          dst   <= alu_y;
          k     <= 3'd0;
          state <= S_SEL;
        end
        // first direction in search order that the distance frees
        S_SEL: begin
          if (alu_neg) begin
            state <= S_MOVE;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_MOVE: begin
          mv      <= sat_coord(alu_y);
          mv_lane <= lane;
          found   <= 1'b1;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            resolved_x      <= res[0];
            resolved_z      <= res[1];
            resolved_y      <= res[2];
            was_overlapping <= ovl;
            gave_up         <= gave;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/push_out_checker.sv
`timescale 1ns / 1ps

// Watches the config, input and result channels of the push-out block,
// keeps its own copy of the collider registers, predicts each result word
// and compares it with what comes out.
module push_out_checker import aabbpo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [CW-1:0]     own_x,
  input  logic signed [CW-1:0]     own_y,
  input  logic signed [CW-1:0]     own_z,
  input  logic signed [CW-1:0]     query_pos_x,
  input  logic signed [CW-1:0]     query_pos_y,
  input  logic signed [CW-1:0]     query_pos_z,
  input  logic [HW-1:0]            query_half_x,
  input  logic [HW-1:0]            query_half_y,
  input  logic [HW-1:0]            query_half_z,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [CW-1:0]     resolved_x,
  input  logic signed [CW-1:0]     resolved_y,
  input  logic signed [CW-1:0]     resolved_z,
  input  logic                     was_overlapping,
  input  logic                     gave_up,
  output int                       mismatches,
  output int                       outstanding,
  output int                       overlap_seen,
  output int                       gaveup_seen
);

  localparam int     MAX_LINES = 40;
  localparam longint RST_HALF  = 256;
  localparam longint RST_STEP  = 26;
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  // one value per axis, exact at 64 bits
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } trip_t;

  // expected result word
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          ovl;
    logic          gave;
  } push_res_t;

  // search order within one round
  typedef enum int {
    PUSH_XP, PUSH_XN, PUSH_ZP, PUSH_ZN, PUSH_YP, PUSH_YN
  } push_dir_t;

  trip_t     coll_half;
  trip_t     coll_off;
  longint    step_q;
  push_res_t expected_q [$];

  // gap on one axis; touching is not a gap
  function automatic bit axis_apart(longint a, longint ah, longint b, longint bh);
    if (a > b) begin
      return (a - ah) > (b + bh);
    end
    return (b - bh) > (a + ah);
  endfunction

  function automatic bit boxes_meet(trip_t c, trip_t ch, trip_t q, trip_t qh);
    return !(axis_apart(c.x, ch.x, q.x, qh.x) || axis_apart(c.y, ch.y, q.y, qh.y) ||
             axis_apart(c.z, ch.z, q.z, qh.z));
  endfunction

  function automatic logic [CW-1:0] clamp_coord(longint v);
    if (v > COORD_MAX) begin
      v = COORD_MAX;
    end else if (v < COORD_MIN) begin
      v = COORD_MIN;
    end
    return v[CW-1:0];
  endfunction

  // overlap test, then rounds of growing distance in the fixed direction order
  function automatic push_res_t predict_push(trip_t own, trip_t qpos, trip_t qhalf);
    trip_t     c;
    trip_t     t;
    trip_t     best;
    bit        hit;
    bit        found;
    longint    d;
    int        r;
    int        k;
    push_res_t p;
    c.x   = own.x + coll_off.x;
    c.y   = own.y + coll_off.y;
    c.z   = own.z + coll_off.z;
    best  = qpos;
    found = 1'b0;
    hit   = boxes_meet(c, coll_half, qpos, qhalf);
    if (hit) begin
      for (r = 1; r <= MAX_ROUNDS && !found; r++) begin
        d = r * step_q;
        for (k = 0; k < 6 && !found; k++) begin
          t = qpos;
          case (k)
            PUSH_XP: t.x = t.x + d;
            PUSH_XN: t.x = t.x - d;
            PUSH_ZP: t.z = t.z + d;
            PUSH_ZN: t.z = t.z - d;
            PUSH_YP: t.y = t.y + d;
            default: t.y = t.y - d;
          endcase
          if (!boxes_meet(c, coll_half, t, qhalf)) begin
            best  = t;
            found = 1'b1;
          end
        end
      end
    end
    p.x    = clamp_coord(best.x);
    p.y    = clamp_coord(best.y);
    p.z    = clamp_coord(best.z);
    p.ovl  = hit;
    p.gave = hit && !found;
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < MAX_LINES) begin
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // monitor: config writes, then result words, then new input words
  always @(posedge clk) begin
    trip_t     own;
    trip_t     qpos;
    trip_t     qhalf;
    push_res_t want;
    if (rst) begin
      coll_half.x = RST_HALF;
      coll_half.y = RST_HALF;
      coll_half.z = RST_HALF;
      coll_off    = '0;
      step_q      = RST_STEP;
      expected_q.delete();
      mismatches   = 0;
      outstanding  = 0;
      overlap_seen = 0;
      gaveup_seen  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HALF_X: coll_half.x = cfg_data[HW-1:0];
          REG_HALF_Y: coll_half.y = cfg_data[HW-1:0];
          REG_HALF_Z: coll_half.z = cfg_data[HW-1:0];
          REG_OFFS_X: coll_off.x  = $signed(cfg_data[CW-1:0]);
          REG_OFFS_Y: coll_off.y  = $signed(cfg_data[CW-1:0]);
          REG_OFFS_Z: coll_off.z  = $signed(cfg_data[CW-1:0]);
          REG_STEP:   step_q      = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result word with none expected, resolved_x", $signed(resolved_x), 0);
        end else begin
          want = expected_q.pop_front();
          if (resolved_x !== want.x)
            report_mismatch("resolved_x", $signed(resolved_x), $signed(want.x));
          if (resolved_y !== want.y)
            report_mismatch("resolved_y", $signed(resolved_y), $signed(want.y));
          if (resolved_z !== want.z)
            report_mismatch("resolved_z", $signed(resolved_z), $signed(want.z));
          if (was_overlapping !== want.ovl)
            report_mismatch("was_overlapping", was_overlapping, want.ovl);
          if (gave_up !== want.gave)
            report_mismatch("gave_up", gave_up, want.gave);
          overlap_seen += want.ovl;
          gaveup_seen  += want.gave;
        end
      end
      if (in_valid && !in_stall) begin
        own.x   = own_x;
        own.y   = own_y;
        own.z   = own_z;
        qpos.x  = query_pos_x;
        qpos.y  = query_pos_y;
        qpos.z  = query_pos_z;
        qhalf.x = query_half_x;
        qhalf.y = query_half_y;
        qhalf.z = query_half_z;
        expected_q.push_back(predict_push(own, qpos, qhalf));
      end
      outstanding = expected_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import aabbpo_pkg::*;

  localparam int     LIMIT_CYCLES = 1_000_000;
  localparam int     DRAIN_CYCLES = 64;
  localparam int     PHASE_WORDS  = 220;
  localparam int     SHORT_WORDS  = 40;
  localparam int     NUM_PHASES   = 6;
  localparam int     ZERO_STEP_PHASE = 3;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint CMAX     = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMIN     = -CMAX - 1;
  localparam longint HMAX     = CMAX;
  localparam longint STEP_MAX = (longint'(1) << STEP_W) - 1;

  typedef struct packed {
    logic signed [CW-1:0] ox, oy, oz;
    logic signed [CW-1:0] qx, qy, qz;
    logic [HW-1:0]        hx, hy, hz;
  } query_word_t;

  localparam int     WORD_BITS = $bits(query_word_t);

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CW-1:0] own_x, own_y, own_z;
  logic signed [CW-1:0] query_pos_x, query_pos_y, query_pos_z;
  logic [HW-1:0]        query_half_x, query_half_y, query_half_z;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [CW-1:0] resolved_x, resolved_y, resolved_z;
  logic                 was_overlapping;
  logic                 gave_up;
  int                   mismatches;
  int                   outstanding;
  int                   overlap_seen;
  int                   gaveup_seen;

  int     cycles;
  int     words_sent;
  int     send_idle_pct;
  int     recv_idle_pct;
  longint cur_half [3];
  longint cur_off [3];
  longint cur_step;

  aabb_overlap_push_out dut (.*);

  push_out_checker chk (.*);

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("run limit of %0d cycles reached, %0d words outstanding", cycles, outstanding);
      $display("aabb_overlap_push_out test failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic longint clamp_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic longint rand_between(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic longint rand_half();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return rand_between(0, 1024);
    if (pick < 90) return rand_between(0, 65535);
    return rand_between(0, HMAX);
  endfunction

  // mostly overlapping words around the collider; some fully random,
  // some touching or just apart on one axis
  function automatic query_word_t rand_word();
    query_word_t w;
    int          mode;
    int          apart_axis;
    int          a;
    longint      own [3];
    longint      qh [3];
    longint      q [3];
    longint      reach;
    longint      delta;
    mode = $urandom_range(99);
    if (mode < 12) begin
      w = WORD_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      return w;
    end
    apart_axis = (mode >= 90) ? $urandom_range(2) : 3;
    for (a = 0; a < 3; a++) begin
      if (mode < 85) begin
        own[a] = rand_between(-(1 << 20), 1 << 20);
      end else begin
        own[a] = $urandom_range(1) ? CMAX - rand_between(0, 4096) : CMIN + rand_between(0, 4096);
      end
      qh[a]  = rand_half();
      reach  = cur_half[a] + qh[a];
      if (a == apart_axis) begin
        delta = reach + $urandom_range(1);
        if ($urandom_range(1)) delta = -delta;
      end else begin
        delta = rand_between(-reach, reach);
      end
      q[a] = clamp_coord(own[a] + cur_off[a] + delta);
    end
    w.ox = CW'(own[0]);
    w.oy = CW'(own[1]);
    w.oz = CW'(own[2]);
    w.qx = CW'(q[0]);
    w.qy = CW'(q[1]);
    w.qz = CW'(q[2]);
    w.hx = HW'(qh[0]);
    w.hy = HW'(qh[1]);
    w.hz = HW'(qh[2]);
    return w;
  endfunction

  // one input word, with random idle cycles ahead of it
  task automatic send_word(input query_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    own_x        <= w.ox;
    own_y        <= w.oy;
    own_z        <= w.oz;
    query_pos_x  <= w.qx;
    query_pos_y  <= w.qy;
    query_pos_z  <= w.qz;
    query_half_x <= w.hx;
    query_half_y <= w.hy;
    query_half_z <= w.hz;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_fields(input longint ox, oy, oz, qx, qy, qz, hx, hy, hz);
    query_word_t w;
    w = {CW'(ox), CW'(oy), CW'(oz), CW'(qx), CW'(qy), CW'(qz), HW'(hx), HW'(hy), HW'(hz)};
    send_word(w);
  endtask

  // stop sending and wait until every result word is back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] wd);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wd;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // register setting per phase; masked bits of the data word carry noise
  task automatic apply_config(input int phase);
    int               a;
    logic [CFG_W-1:0] wd;
    for (a = 0; a < 3; a++) begin
      case (phase)
        0, 3, 4: begin
          cur_half[a] = rand_between(64, 2048);
          cur_off[a]  = (phase == ZERO_STEP_PHASE) ? 0 : rand_between(-4096, 4096);
        end
        1: begin
          cur_half[a] = HMAX;
          cur_off[a]  = CMAX;
        end
        2: begin
          cur_half[a] = 0;
          cur_off[a]  = CMIN;
        end
        default: begin
          cur_half[a] = rand_between(0, HMAX);
          cur_off[a]  = rand_between(CMIN, CMAX);
        end
      endcase
    end
    case (phase)
      0:       cur_step = rand_between(8, 120);
      1:       cur_step = STEP_MAX;
      2:       cur_step = 1;
      3:       cur_step = 0;
      4:       cur_step = rand_between(1, 300);
      default: cur_step = rand_between(0, STEP_MAX);
    endcase
    if (phase == ZERO_STEP_PHASE) write_reg(REG_UNUSED, CFG_W'($urandom));
    for (a = 0; a < 3; a++) begin
      wd           = CFG_W'($urandom);
      wd[HW-1:0]   = cur_half[a][HW-1:0];
      write_reg(reg_idx_t'(REG_HALF_X + a), wd);
      write_reg(reg_idx_t'(REG_OFFS_X + a), cur_off[a][CW-1:0]);
    end
    wd                 = CFG_W'($urandom);
    wd[STEP_W-1:0]     = cur_step[STEP_W-1:0];
    write_reg(REG_STEP, wd);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int n;
    int words;
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    own_x        = '0;
    own_y        = '0;
    own_z        = '0;
    query_pos_x  = '0;
    query_pos_y  = '0;
    query_pos_z  = '0;
    query_half_x = '0;
    query_half_y = '0;
    query_half_z = '0;
    out_stall    = 1'b0;
    cycles       = 0;
    words_sent   = 0;
    send_idle_pct = 17;
    recv_idle_pct = 72;
    for (n = 0; n < 3; n++) begin
      cur_half[n] = 256;
      cur_off[n]  = 0;
    end
    cur_step = 26;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words under the reset setting
    send_fields(0, 0, 0, 4096, 0, 0, 256, 256, 256);          // clear of the collider
    send_fields(0, 0, 0, 512, 0, 0, 256, 256, 256);           // touching on x
    send_fields(0, 0, 0, 513, 0, 0, 256, 256, 256);           // one apart on x
    send_fields(0, 0, 0, 0, 0, 0, 256, 256, 256);             // centred, +x wins the tie
    send_fields(0, 0, 0, -100, 0, 0, 256, 256, 256);          // -x first free
    send_fields(0, 0, 0, 0, 0, 100, 2000, 256, 256);          // +z
    send_fields(0, 0, 0, 0, 0, -100, 2000, 256, 256);         // -z
    send_fields(0, 0, 0, 0, 50, 0, 2000, 256, 2000);          // +y
    send_fields(0, 0, 0, 0, -50, 0, 2000, 256, 2000);         // -y
    send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0);                   // all zero
    send_fields(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, HMAX, HMAX, HMAX); // runs out of rounds
    send_fields(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0, 0, 0);
    send_fields(CMAX, 0, 0, CMAX, 0, 0, 256, 256, 256);       // +x clamps high
    send_fields(CMIN + 10, 0, 0, CMIN, 0, 0, 256, 256, 256);  // -x clamps low
    send_fields(0, CMAX, 0, 0, CMAX, 0, 4000, 256, 4000);     // +y clamps high
    send_fields(0, 0, CMIN + 10, 0, 0, CMIN, 4000, 4000, 256); // -z clamps low
    send_fields(0, 0, 0, 0, 600, 0, 256, 256, 256);           // apart on y only
    send_fields(0, 0, 0, 0, 0, -600, 256, 256, 256);          // apart on z only
    send_fields(0, 0, 0, 0, 0, 0, HMAX, 0, 0);                // wide x, z frees first
    send_fields(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0); // opposite corners
    wait_idle();

    // random words, one register setting per phase
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 17;
        recv_idle_pct = 72;
      end else if (phase < 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_config(phase);
      words = (phase == ZERO_STEP_PHASE) ? SHORT_WORDS : PHASE_WORDS;
      for (n = 0; n < words; n++) begin
        send_word(rand_word());
        if ($urandom_range(149) == 0) wait_idle();
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d words over the reset setting and %0d register settings, idle mixes 17/72, 72/17, none",
             words_sent, NUM_PHASES);
    $display("%0d overlapped at entry, %0d exhausted the search", overlap_seen, gaveup_seen);
    if (outstanding != 0) $display("%0d result words never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("aabb_overlap_push_out test passed");
    end else begin
      $display("aabb_overlap_push_out test failed");
    end
    $finish;
  end

endmodule
